// ===== rtl/earth_frame_rotation_top_assert.svh =====
// assertion helpers for the rotation block
`ifndef EARTH_FRAME_ROTATION_TOP_ASSERT_SVH
`define EARTH_FRAME_ROTATION_TOP_ASSERT_SVH

// same-cycle implication
`define EFR_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("efr assertion failed");

// next-cycle implication
`define EFR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("efr assertion failed");

`endif

// ===== rtl/efr_pkg.sv =====
package efr_pkg;

  localparam int unsigned CordicStagesDef = 24;
  localparam int unsigned TimeW   = 40;
  localparam int unsigned FieldW  = 32;
  localparam int unsigned AngW    = 34;
  localparam int unsigned ProdW   = 66;
  localparam int unsigned SumW    = 70;
  localparam int unsigned InDataW = 176;
  localparam int unsigned OutDataW = 128;

  localparam logic [29:0] PhaseRate = 30'd816682953;
  localparam logic signed [AngW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [24:0] EarthRateQ30 = 25'sd5011104;

  localparam logic OpToFixed   = 1'b0;
  localparam logic OpToInertial = 1'b1;

  typedef struct packed {
    logic                     op;
    logic signed [FieldW-1:0] pos_x;
    logic signed [FieldW-1:0] pos_y;
    logic signed [FieldW-1:0] vel_x;
    logic signed [FieldW-1:0] vel_y;
  } item_t;

  typedef struct packed {
    logic signed [AngW-1:0] x;
    logic signed [AngW-1:0] y;
    logic signed [AngW-1:0] z;
    logic [1:0]             q;
  } rot_t;

  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // round to nearest at q30 then clamp to 32 bits
  function automatic logic signed [FieldW-1:0] round_sat(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] s;
    logic signed [SumW-31:0] r;
    logic signed [FieldW-1:0] o;
    s = v + (SumW'(1) <<< 29);
    r = s[SumW-1:30];
    if (r > $signed({{(SumW-30-FieldW){1'b0}}, 1'b0, {(FieldW-1){1'b1}}}))
      o = {1'b0, {(FieldW-1){1'b1}}};
    else if (r < $signed({{(SumW-30-FieldW){1'b1}}, 1'b1, {(FieldW-1){1'b0}}}))
      o = {1'b1, {(FieldW-1){1'b0}}};
    else
      o = r[FieldW-1:0];
    return o;
  endfunction

endpackage

// ===== rtl/earth_frame_rotation_top.sv =====
// channel   | dir | tdata fields, lsb first
// s_axis    | in  | op, time_s, pos_x, pos_y, vel_x, vel_y (176 bits)
// m_axis    | out | new_pos_x, new_pos_y, new_vel_x, new_vel_y (128 bits)
// one request per cycle while m_axis is not stalled; pipeline stages:
// 2 phase stages: multiply, then sum and fold; one cordic cell per stage; 4 output stages
// every stage has its own valid and holds under backpressure, bubbles close up
// reset clears only the stage valid bits and the in-flight count
module earth_frame_rotation_top import efr_pkg::*; #(
  parameter int unsigned CordicStages = CordicStagesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // op, time_s, pos_x, pos_y, vel_x, vel_y, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // new_pos_x, new_pos_y, new_vel_x, new_vel_y
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned Depth = CordicStages + 6;

  item_t in_item;
  logic  vld [CordicStages+1];
  logic  rdy [CordicStages+1];
  rot_t  rot [CordicStages+1];
  item_t itm [CordicStages+1];
  logic signed [FieldW-1:0] npx, npy, nvx, nvy;
  logic [$clog2(Depth+2)-1:0] cnt_q;

  assign in_item.op    = s_axis_tdata[0];
  assign in_item.pos_x = s_axis_tdata[72:41];
  assign in_item.pos_y = s_axis_tdata[104:73];
  assign in_item.vel_x = s_axis_tdata[136:105];
  assign in_item.vel_y = s_axis_tdata[168:137];

  efr_phase u_phase (
    .clk_i, .rst_ni,
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .time_i  (s_axis_tdata[40:1]),
    .item_i  (in_item),
    .valid_o (vld[0]),
    .ready_i (rdy[0]),
    .rot_o   (rot[0]),
    .item_o  (itm[0])
  );

  for (genvar i = 0; i < CordicStages; i++) begin : g_cell
    efr_cordic_cell #(.Idx(i)) u_cell (
      .clk_i, .rst_ni,
      .valid_i (vld[i]),
      .ready_o (rdy[i]),
      .rot_i   (rot[i]),
      .item_i  (itm[i]),
      .valid_o (vld[i+1]),
      .ready_i (rdy[i+1]),
      .rot_o   (rot[i+1]),
      .item_o  (itm[i+1])
    );
  end

  efr_post u_post (
    .clk_i, .rst_ni,
    .valid_i     (vld[CordicStages]),
    .ready_o     (rdy[CordicStages]),
    .rot_i       (rot[CordicStages]),
    .item_i      (itm[CordicStages]),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .new_pos_x_o (npx),
    .new_pos_y_o (npy),
    .new_vel_x_o (nvx),
    .new_vel_y_o (nvy)
  );

  assign m_axis_tdata = {nvy, nvx, npy, npx};

  // requests in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + $bits(cnt_q)'(s_axis_tvalid && s_axis_tready)
                     - $bits(cnt_q)'(m_axis_tvalid && m_axis_tready);
    end
  end

`include "earth_frame_rotation_top_assert.svh"

  `EFR_ASSERT_NOW(a_stall_only_from_out, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
  `EFR_ASSERT_NOW(a_depth_bound, 1'b1, cnt_q <= $bits(cnt_q)'(Depth))
  `EFR_ASSERT_NOW(a_out_has_item, m_axis_tvalid, cnt_q != '0)

endmodule

// ===== rtl/efr_phase.sv =====
module efr_phase import efr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic signed [TimeW-1:0] time_i,
  input  item_t                   item_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output rot_t                    rot_o,
  output item_t                   item_o
);

  logic              v1_q, v2_q;
  logic              rdy1, rdy2;
  logic [49:0]       pl_q;
  logic signed [50:0] ph_q;
  item_t             it1_q, it2_q;
  rot_t              rot_q;
  logic [55:0]       full;
  logic [31:0]       phase;
  logic [1:0]        q;
  logic [31:0]       d;

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  // split time so each partial product stays narrow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      pl_q  <= time_i[19:0] * PhaseRate;
      ph_q  <= $signed(time_i[39:20]) * $signed({1'b0, PhaseRate});
      it1_q <= item_i;
    end
  end

  assign full  = {ph_q[35:0], 20'd0} + {6'd0, pl_q};
  assign phase = full[55:24];
  assign q     = 2'((phase + 32'h20000000) >> 30);
  assign d     = phase - {q, 30'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      rot_q.x <= CordicGain;
      rot_q.y <= '0;
      rot_q.z <= {{(AngW-32){d[31]}}, d};
      rot_q.q <= q;
      it2_q   <= it1_q;
    end
  end

  assign valid_o = v2_q;
  assign rot_o   = rot_q;
  assign item_o  = it2_q;

endmodule

// ===== rtl/efr_cordic_cell.sv =====
module efr_cordic_cell import efr_pkg::*; #(
  parameter int unsigned Idx = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  rot_t  rot_i,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  ready_i,
  output rot_t  rot_o,
  output item_t item_o
);

  logic                   v_q;
  rot_t                   rot_q;
  item_t                  it_q;
  logic signed [AngW-1:0] xs, ys, at;
  rot_t                   nxt;

  assign ready_o = !v_q || ready_i;
  assign xs = rot_i.x >>> Idx;
  assign ys = rot_i.y >>> Idx;
  assign at = {{(AngW-32){1'b0}}, atan_turns(5'(Idx))};

  always_comb begin
    nxt = rot_i;
    if (!rot_i.z[AngW-1]) begin
      nxt.x = rot_i.x - ys;
      nxt.y = rot_i.y + xs;
      nxt.z = rot_i.z - at;
    end else begin
      nxt.x = rot_i.x + ys;
      nxt.y = rot_i.y - xs;
      nxt.z = rot_i.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rot_q <= nxt;
      it_q  <= item_i;
    end
  end

  assign valid_o = v_q;
  assign rot_o   = rot_q;
  assign item_o  = it_q;

endmodule

// ===== rtl/efr_post.sv =====
module efr_post import efr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  rot_t                     rot_i,
  input  item_t                    item_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic signed [FieldW-1:0] new_pos_x_o,
  output logic signed [FieldW-1:0] new_pos_y_o,
  output logic signed [FieldW-1:0] new_vel_x_o,
  output logic signed [FieldW-1:0] new_vel_y_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic r1, r2, r3, r4;
  logic op1_q, op2_q, op3_q;
  logic signed [AngW-1:0] c, s, sd;
  logic signed [ProdW-1:0] p_q [8];
  logic signed [SumW-1:0] nx_q, ny_q, vx_q, vy_q;
  logic signed [SumW-1:0] nx3_q, ny3_q, vx3_q, vy3_q, cxp_q, cyp_q;
  logic signed [SumW-1:0] cx, cy, vx, vy;
  logic signed [FieldW-1:0] o_q [4];

  assign r4 = !v4_q || ready_i;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign ready_o = r1;

  always_comb begin
    case (rot_i.q)
      2'd0:    begin c = rot_i.x;  s = rot_i.y;  end
      2'd1:    begin c = -rot_i.y; s = rot_i.x;  end
      2'd2:    begin c = -rot_i.x; s = -rot_i.y; end
      default: begin c = rot_i.y;  s = -rot_i.x; end
    endcase
    sd = (item_i.op == OpToInertial) ? -s : s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r1) v1_q <= valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  // rotation products
  always_ff @(posedge clk_i) begin
    if (r1 && valid_i) begin
      p_q[0] <= c  * item_i.pos_x;
      p_q[1] <= sd * item_i.pos_y;
      p_q[2] <= sd * item_i.pos_x;
      p_q[3] <= c  * item_i.pos_y;
      p_q[4] <= c  * item_i.vel_x;
      p_q[5] <= sd * item_i.vel_y;
      p_q[6] <= sd * item_i.vel_x;
      p_q[7] <= c  * item_i.vel_y;
      op1_q  <= item_i.op;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      nx_q  <= SumW'(p_q[0]) + SumW'(p_q[1]);
      ny_q  <= SumW'(p_q[3]) - SumW'(p_q[2]);
      vx_q  <= SumW'(p_q[4]) + SumW'(p_q[5]);
      vy_q  <= SumW'(p_q[7]) - SumW'(p_q[6]);
      op2_q <= op1_q;
    end
  end

  // earth-rate cross-product terms, position sums fit in 64 bits
  always_ff @(posedge clk_i) begin
    if (r3 && v2_q) begin
      cxp_q <= SumW'($signed(ny_q[2*FieldW-1:22]) * EarthRateQ30);
      cyp_q <= SumW'($signed(nx_q[2*FieldW-1:22]) * EarthRateQ30);
      nx3_q <= nx_q;
      ny3_q <= ny_q;
      vx3_q <= vx_q;
      vy3_q <= vy_q;
      op3_q <= op2_q;
    end
  end

  assign cx = cxp_q >>> 8;
  assign cy = cyp_q >>> 8;
  assign vx = (op3_q == OpToFixed) ? vx3_q + cx : vx3_q - cx;
  assign vy = (op3_q == OpToFixed) ? vy3_q - cy : vy3_q + cy;

  always_ff @(posedge clk_i) begin
    if (r4 && v3_q) begin
      o_q[0] <= round_sat(nx3_q);
      o_q[1] <= round_sat(ny3_q);
      o_q[2] <= round_sat(vx);
      o_q[3] <= round_sat(vy);
    end
  end

  assign valid_o     = v4_q;
  assign new_pos_x_o = o_q[0];
  assign new_pos_y_o = o_q[1];
  assign new_vel_x_o = o_q[2];
  assign new_vel_y_o = o_q[3];

endmodule

// ===== bench/earth_frame_rotation_top_tb.sv =====
`timescale 1ns / 1ps

module earth_frame_rotation_top_tb;
  import efr_pkg::*;

  localparam int unsigned NumStages = CordicStagesDef;
  localparam int unsigned RandItems = 650;
  localparam int unsigned CycleLimit = 400000;

  // per-stage arctangents in 2^-32 turn
  localparam longint AtanTab [32] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
    64'h00000001, 64'h00000000};

  class rotation_scoreboard;
    logic [OutDataW-1:0] expected_q[$];
    int errors;

    function logic [31:0] to_field(longint v);
      longint r;
      r = (v + (64'sd1 <<< 29)) >>> 30;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
    endfunction

    function logic [OutDataW-1:0] rotate_frame(logic [InDataW-1:0] d);
      logic op;
      longint t, x0, x1, v0, v1, x, y, z, xs, ys, c, s, sd, nx, ny, vx, vy, cx, cy;
      longint unsigned prod;
      logic [31:0] phase, resid;
      logic [1:0] q;
      op = d[0];
      t = longint'($signed(d[40:1]));
      x0 = longint'($signed(d[72:41]));
      x1 = longint'($signed(d[104:73]));
      v0 = longint'($signed(d[136:105]));
      v1 = longint'($signed(d[168:137]));
      prod = longint'(t) * 64'd816682953;
      phase = prod[55:24];
      q = 2'((phase + 32'h20000000) >> 30);
      resid = phase - ({30'd0, q} << 30);
      z = longint'($signed(resid));
      x = 652032874;
      y = 0;
      for (int i = 0; i < NumStages && i < 32; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= AtanTab[i];
        end else begin
          x += ys; y -= xs; z += AtanTab[i];
        end
      end
      case (q)
        2'd0: begin c = x; s = y; end
        2'd1: begin c = -y; s = x; end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
      sd = (op == OpToInertial) ? -s : s;
      nx = c * x0 + sd * x1;
      ny = -sd * x0 + c * x1;
      vx = c * v0 + sd * v1;
      vy = -sd * v0 + c * v1;
      cx = ((ny >>> 22) * 5011104) >>> 8;
      cy = ((nx >>> 22) * 5011104) >>> 8;
      if (op == OpToFixed) begin
        vx += cx; vy -= cy;
      end else begin
        vx -= cx; vy += cy;
      end
      return {to_field(vy), to_field(vx), to_field(ny), to_field(nx)};
    endfunction

    function void note_request(logic [InDataW-1:0] d);
      expected_q.push_back(rotate_frame(d));
    endfunction

    function void check_result(logic [OutDataW-1:0] got);
      logic [OutDataW-1:0] exp_d;
      bit bad;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_d = expected_q.pop_front();
      bad = 0;
      for (int f = 0; f < 4; f++)
        if (got[f*32 +: 32] !== exp_d[f*32 +: 32]) bad = 1;
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display("mismatch pos_x %h/%h pos_y %h/%h vel_x %h/%h vel_y %h/%h (exp/got)",
                   exp_d[31:0], got[31:0], exp_d[63:32], got[63:32],
                   exp_d[95:64], got[95:64], exp_d[127:96], got[127:96]);
      end
    endfunction
  endclass

  logic                clk_i = 0;
  logic                rst_ni = 0;
  logic                s_axis_tvalid = 0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 0;
  logic [OutDataW-1:0] m_axis_tdata;

  rotation_scoreboard frame_sb = new();
  int send_idle_pct, recv_idle_pct;
  int hold_req;
  int cycles;

  earth_frame_rotation_top DUT (.*);

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) frame_sb.note_request(s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready) frame_sb.check_result(m_axis_tdata);
  end

  // receiver, with a long hold-off when asked
  int hold_left;
  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_request(logic op, logic [39:0] t, logic [31:0] px, logic [31:0] py,
                              logic [31:0] vx, logic [31:0] vy);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, vy, vx, py, px, t, op};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random(int n);
    logic [39:0] t;
    for (int i = 0; i < n; i++) begin
      t = 40'({$urandom, $urandom});
      // half modest times, half over the full range
      case ($urandom_range(3))
        0: t = 40'($signed(t[23:0]));
        1: t = 40'($signed(t[31:0]));
        default: ;
      endcase
      send_request(1'($urandom_range(1)), t, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (frame_sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    send_idle_pct = 24;
    recv_idle_pct = 88;
    hold_req = 0;
    cycles = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes, both directions, quadrant edges, negative and wrapping time
    for (int op = 0; op < 2; op++) begin
      send_request(1'(op), 40'd0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      send_request(1'(op), 40'd0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      send_request(1'(op), 40'h7fffffffff, 32'h7fffffff, 32'h80000000, 32'h1234,
                   32'hffff0000);
      send_request(1'(op), 40'h8000000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h0);
      send_request(1'(op), 40'hffffffffff, 32'd100000, 32'hfff00000, 32'd5000, 32'hffffc000);
      send_request(1'(op), 40'd22127616, 32'h7fffffff, 32'h7fffffff, 32'h0, 32'h0);
      send_request(1'(op), 40'd44255232, 32'h40000000, 32'hc0000000, 32'h80000000,
                   32'h7fffffff);
      send_request(1'(op), 40'd66382848, 32'h0, 32'h0, 32'h0, 32'h0);
      send_request(1'(op), 40'd11063808, 32'd104857600, 32'd0, 32'd7864320, 32'd0);
      send_request(1'(op), 40'hfffd5c0000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                   32'h80000000);
    end
    send_random(RandItems / 3 - 20);
    drain();

    send_idle_pct = 88;
    recv_idle_pct = 24;
    send_random(RandItems / 3);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 300;
    send_random(RandItems / 3 + 20);
    drain();

    repeat (2 * (NumStages + 6)) @(posedge clk_i);
    if (frame_sb.errors == 0 && frame_sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
